@@ rtl/hvn_pkg.sv @@
// Package for the height-map vertex normal block.
// Holds shared widths, state encodings, the payload structs and the face-sum function.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package hvn_pkg;

    localparam int MAX_WIDTH_DEF = 256;
    localparam int ROWS_MAX      = 4096;
    localparam int HEIGHT_ONE    = 256;

    localparam int HEIGHT_W = 16;
    localparam int SUM_W    = 19;
    localparam int SY_W     = 11;
    localparam int MAG_W    = 18;
    localparam int SQ_W     = 36;
    localparam int LEN_W    = 38;
    localparam int REM_W    = 39;
    localparam int QUO_W    = 29;
    localparam int NRM_W    = 16;
    localparam int NY_W     = 15;
    localparam int COL_W    = 8;
    localparam int ROW_W    = 12;
    localparam int GW_W     = 9;
    localparam int GR_W     = 13;
    localparam int CFG_W    = 13;
    localparam int STEP_W   = 5;

    localparam int GW_RESET = 128;
    localparam int GR_RESET = 128;

    // Last step index of the restoring division and of the square root.
    localparam int DIV_LAST  = 28;
    localparam int ROOT_LAST = 14;

    typedef enum logic [0:0] {
        CFG_GRID_WIDTH = 1'b0,
        CFG_GRID_ROWS  = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_READ,
        MS_WRITE,
        MS_SUM,
        MS_NORM,
        MS_PUSH
    } main_state_t;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_SQUARE,
        NS_LENGTH,
        NS_LOAD,
        NS_DIVIDE,
        NS_ROOT,
        NS_STORE
    } norm_state_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sx;
        logic [SY_W-1:0]         sy;
        logic signed [SUM_W-1:0] sz;
    } hvn_sum_t;

    typedef struct packed {
        logic     start;
        hvn_sum_t sum;
    } hvn_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [NRM_W-1:0] nx;
        logic [NY_W-1:0]         ny;
        logic signed [NRM_W-1:0] nz;
    } hvn_rsp_t;

    // Sum of the up to four face normals that touch one vertex.
    function automatic hvn_sum_t face_sums(
        input logic signed [HEIGHT_W-1:0] t0, t1, t2,
        input logic signed [HEIGHT_W-1:0] m0, m1, m2,
        input logic signed [HEIGHT_W-1:0] b0, b1,
        input logic up, down, left, right
    );
        hvn_sum_t s;
        s.sx = '0;
        s.sy = '0;
        s.sz = '0;
        if (up && left)
        begin
            s.sx = s.sx + SUM_W'(t0) - SUM_W'(t1);
            s.sz = s.sz + SUM_W'(t0) - SUM_W'(m0);
            s.sy = s.sy + SY_W'(HEIGHT_ONE);
        end
        if (up && right)
        begin
            s.sx = s.sx + SUM_W'(t1) - SUM_W'(t2);
            s.sz = s.sz + SUM_W'(t1) - SUM_W'(m1);
            s.sy = s.sy + SY_W'(HEIGHT_ONE);
        end
        if (down && left)
        begin
            s.sx = s.sx + SUM_W'(m0) - SUM_W'(m1);
            s.sz = s.sz + SUM_W'(m0) - SUM_W'(b0);
            s.sy = s.sy + SY_W'(HEIGHT_ONE);
        end
        if (down && right)
        begin
            s.sx = s.sx + SUM_W'(m1) - SUM_W'(m2);
            s.sz = s.sz + SUM_W'(m1) - SUM_W'(b1);
            s.sy = s.sy + SY_W'(HEIGHT_ONE);
        end
        return s;
    endfunction

endpackage

@@ rtl/hvn_if.sv @@
// Valid/ready stream interfaces for height samples and vertex normals.
// Depends on hvn_pkg for the field widths.
interface hvn_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [hvn_pkg::HEIGHT_W-1:0]    height;
    modport source (output valid, output height, input ready);
    modport sink   (input valid, input height, output ready);
endinterface

interface hvn_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [hvn_pkg::NRM_W-1:0]       normal_x;
    logic [hvn_pkg::NY_W-1:0]               normal_y;
    logic signed [hvn_pkg::NRM_W-1:0]       normal_z;
    logic [hvn_pkg::COL_W-1:0]              vertex_col;
    logic [hvn_pkg::ROW_W-1:0]              vertex_row;
    logic                                   last_of_run;
    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output vertex_col, output vertex_row, output last_of_run, input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    input vertex_col, input vertex_row, input last_of_run, output ready);
endinterface

@@ rtl/hvn_norm.sv @@
// Iterative normaliser: turns a summed normal into a unit vector in Q1.14.
// Depends on hvn_pkg. One shared squarer, a bit-serial divider and a bit-serial root.
module hvn_norm
(
    input  logic              clk,
    input  logic              rst_n,
    input  hvn_pkg::hvn_req_t req,
    output hvn_pkg::hvn_rsp_t rsp
);

    hvn_pkg::norm_state_t state_reg, state_next;

    hvn_pkg::hvn_sum_t                 sum_reg;
    logic [1:0]                        idx_reg, idx_next;
    logic [hvn_pkg::SQ_W-1:0]          sq_reg [3];
    logic [hvn_pkg::LEN_W-1:0]         len_reg;
    logic [hvn_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [hvn_pkg::QUO_W-1:0]         quo_reg, quo_next;
    logic [hvn_pkg::QUO_W-1:0]         res_reg, res_next;
    logic [hvn_pkg::QUO_W-1:0]         bit_reg, bit_next;
    logic [hvn_pkg::STEP_W-1:0]        step_reg, step_next;
    logic                              done_reg;
    logic signed [hvn_pkg::NRM_W-1:0]  nx_reg, nz_reg;
    logic [hvn_pkg::NY_W-1:0]          ny_reg;

    logic [hvn_pkg::MAG_W-1:0]         mag;
    logic [hvn_pkg::SQ_W-1:0]          sq;
    logic [hvn_pkg::REM_W-1:0]         trial;
    logic [hvn_pkg::QUO_W-1:0]         root_sum;
    logic [hvn_pkg::NY_W-1:0]          q;
    logic signed [hvn_pkg::NRM_W-1:0]  q_pos, q_neg;

    // Magnitude of the component picked by the index.
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    mag = sum_reg.sx[hvn_pkg::SUM_W-1] ?
                           hvn_pkg::MAG_W'(-sum_reg.sx) : hvn_pkg::MAG_W'(sum_reg.sx);
            2'd1:    mag = hvn_pkg::MAG_W'(sum_reg.sy);
            default: mag = sum_reg.sz[hvn_pkg::SUM_W-1] ?
                           hvn_pkg::MAG_W'(-sum_reg.sz) : hvn_pkg::MAG_W'(sum_reg.sz);
        endcase
    end

    assign sq       = mag * mag;
    assign trial    = (step_reg == '0) ? rem_reg : {rem_reg[hvn_pkg::REM_W-2:0], 1'b0};
    assign root_sum = res_reg + bit_reg;
    assign q        = res_reg[hvn_pkg::NY_W-1:0];
    assign q_pos    = hvn_pkg::NRM_W'(q);
    assign q_neg    = -q_pos;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hvn_pkg::NS_IDLE:   if (req.start) state_next = hvn_pkg::NS_SQUARE;
            hvn_pkg::NS_SQUARE: if (idx_reg == 2'd2) state_next = hvn_pkg::NS_LENGTH;
            hvn_pkg::NS_LENGTH: state_next = hvn_pkg::NS_LOAD;
            hvn_pkg::NS_LOAD:   state_next = hvn_pkg::NS_DIVIDE;
            hvn_pkg::NS_DIVIDE:
                if (step_reg == hvn_pkg::STEP_W'(hvn_pkg::DIV_LAST))
                    state_next = hvn_pkg::NS_ROOT;
            hvn_pkg::NS_ROOT:
                if (step_reg == hvn_pkg::STEP_W'(hvn_pkg::ROOT_LAST))
                    state_next = hvn_pkg::NS_STORE;
            hvn_pkg::NS_STORE:
                state_next = (idx_reg == 2'd2) ? hvn_pkg::NS_IDLE : hvn_pkg::NS_LOAD;
            default:            state_next = hvn_pkg::NS_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next  = idx_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        step_next = step_reg;
        unique case (state_reg)
            hvn_pkg::NS_IDLE:   idx_next = '0;
            hvn_pkg::NS_SQUARE: idx_next = (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
            hvn_pkg::NS_LENGTH: idx_next = '0;
            hvn_pkg::NS_LOAD:
            begin
                rem_next  = hvn_pkg::REM_W'(sq_reg[idx_reg]);
                quo_next  = '0;
                step_next = '0;
            end
            hvn_pkg::NS_DIVIDE:
            begin
                if (trial >= hvn_pkg::REM_W'(len_reg))
                begin
                    rem_next = trial - hvn_pkg::REM_W'(len_reg);
                    quo_next = {quo_reg[hvn_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[hvn_pkg::QUO_W-2:0], 1'b0};
                end
                if (step_reg == hvn_pkg::STEP_W'(hvn_pkg::DIV_LAST))
                begin
                    step_next = '0;
                    res_next  = '0;
                    bit_next  = {1'b1, {(hvn_pkg::QUO_W-1){1'b0}}};
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            hvn_pkg::NS_ROOT:
            begin
                // The quotient register serves as the remaining radicand here.
                if (quo_reg >= root_sum)
                begin
                    quo_next = quo_reg - root_sum;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + 1'b1;
            end
            hvn_pkg::NS_STORE:  idx_next = idx_reg + 2'd1;
            default:            idx_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hvn_pkg::NS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == hvn_pkg::NS_STORE) && (idx_reg == 2'd2);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        step_reg <= step_next;
        if (state_reg == hvn_pkg::NS_IDLE && req.start)
            sum_reg <= req.sum;
        if (state_reg == hvn_pkg::NS_SQUARE)
            sq_reg[idx_reg] <= sq;
        if (state_reg == hvn_pkg::NS_LENGTH)
            len_reg <= hvn_pkg::LEN_W'(sq_reg[0]) + hvn_pkg::LEN_W'(sq_reg[1])
                     + hvn_pkg::LEN_W'(sq_reg[2]);
        if (state_reg == hvn_pkg::NS_STORE)
        begin
            unique case (idx_reg)
                2'd0:    nx_reg <= sum_reg.sx[hvn_pkg::SUM_W-1] ? q_neg : q_pos;
                2'd1:    ny_reg <= q;
                default: nz_reg <= sum_reg.sz[hvn_pkg::SUM_W-1] ? q_neg : q_pos;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.nx   = nx_reg;
    assign rsp.ny   = ny_reg;
    assign rsp.nz   = nz_reg;

endmodule

@@ rtl/heightmap_vertex_normals.sv @@
// Top level of the height-map vertex normal block: row stores, control and output register.
// Depends on hvn_pkg, the stream interfaces in hvn_if.sv and the normaliser hvn_norm.
//
//   Channel   Role     Payload                                       Width
//   samples   sink     height (signed Q8.8)                          16
//   normals   source   normal_x/y/z, vertex_col, vertex_row, last    16/15/16/8/12/1
//   cfg       write    cfg_we, cfg_index, cfg_data                   1/1/13
//
// A sample passes through its own steps: accept, the reads of the three row-store columns
// (read data trails its address) and two write-backs. Each normal it produces then waits on
// the bit-serial divider and square root in hvn_norm, which run three times per normal.
// A sample on the last row yields two. Reset clears the counters and the handshakes and
// loads the default configuration; the row stores are not
// cleared. A stalled output holds its result and keeps the next normal waiting in hvn_norm.
module heightmap_vertex_normals
#(
    parameter int MAX_WIDTH = hvn_pkg::MAX_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [hvn_pkg::CFG_W-1:0]  cfg_data,
    hvn_in_if.sink                     samples,
    hvn_out_if.source                  normals
);

    localparam int AW  = $clog2(MAX_WIDTH);
    // Width wide enough to compare column counts with the configured row width.
    localparam int WCW = (AW + 1 > hvn_pkg::GW_W) ? AW + 1 : hvn_pkg::GW_W;

    typedef logic signed [hvn_pkg::HEIGHT_W-1:0] height_t;

    hvn_pkg::main_state_t state_reg, state_next;

    // Configuration.
    logic [hvn_pkg::GW_W-1:0]  grid_width_reg;
    logic [hvn_pkg::GR_W-1:0]  grid_rows_reg;

    // Stream position and previous sample.
    logic [AW-1:0]             col_count_reg;
    logic [hvn_pkg::ROW_W-1:0] row_count_reg;
    height_t                   left_sample_reg;

    // Row stores: the previous row and the one before it.
    height_t                   row_one_mem [MAX_WIDTH];
    height_t                   row_two_mem [MAX_WIDTH];
    height_t                   rd_one_reg, rd_two_reg;
    logic [AW-1:0]             rd_addr, wr_addr;
    logic                      mem_we;
    height_t                   wd_one, wd_two;

    // Working copy of the accepted transaction.
    logic [AW-1:0]             c_reg;
    logic [hvn_pkg::ROW_W-1:0] r_reg;
    logic                      left_reg, right_reg, last_row_reg;
    height_t                   h_reg, lsamp_reg;
    height_t                   t_reg [3];
    height_t                   m_reg [3];
    logic [1:0]                rd_cnt_reg;
    logic                      wr_cnt_reg;
    logic                      vsel_reg;

    // Output register.
    logic                              out_valid_reg;
    logic signed [hvn_pkg::NRM_W-1:0]  nx_reg, nz_reg;
    logic [hvn_pkg::NY_W-1:0]          ny_reg;
    logic [hvn_pkg::COL_W-1:0]         col_out_reg;
    logic [hvn_pkg::ROW_W-1:0]         row_out_reg;
    logic                              last_out_reg;

    // Position of the incoming sample, with both counts clamped to the grid.
    logic [WCW-1:0]            gw_ext, w_eff, w_last, col_ext, c_full;
    logic [hvn_pkg::GR_W-1:0]  rows_eff;
    logic [hvn_pkg::ROW_W-1:0] rows_last, r_cur;
    logic [AW-1:0]             c_cur;
    logic                      left_cur, right_cur, last_row_cur;

    logic                      accept, slot_free, push;
    hvn_pkg::hvn_req_t         req;
    hvn_pkg::hvn_rsp_t         rsp;

    always_comb
    begin
        gw_ext = WCW'(grid_width_reg);
        if (gw_ext < WCW'(2))
            w_eff = WCW'(2);
        else if (gw_ext > WCW'(MAX_WIDTH))
            w_eff = WCW'(MAX_WIDTH);
        else
            w_eff = gw_ext;
        w_last  = w_eff - WCW'(1);
        col_ext = WCW'(col_count_reg);
        c_full  = (col_ext > w_last) ? w_last : col_ext;
        c_cur   = c_full[AW-1:0];

        if (grid_rows_reg < hvn_pkg::GR_W'(2))
            rows_eff = hvn_pkg::GR_W'(2);
        else if (grid_rows_reg > hvn_pkg::GR_W'(hvn_pkg::ROWS_MAX))
            rows_eff = hvn_pkg::GR_W'(hvn_pkg::ROWS_MAX);
        else
            rows_eff = grid_rows_reg;
        rows_last = hvn_pkg::ROW_W'(rows_eff - hvn_pkg::GR_W'(1));
        r_cur     = (row_count_reg > rows_last) ? rows_last : row_count_reg;

        left_cur     = (c_cur != '0);
        right_cur    = (c_full != w_last);
        last_row_cur = (r_cur == rows_last);
    end

    assign accept    = samples.valid && samples.ready;
    assign slot_free = !out_valid_reg || normals.ready;
    assign push      = (state_reg == hvn_pkg::MS_PUSH) && slot_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hvn_pkg::MS_IDLE:  if (samples.valid) state_next = hvn_pkg::MS_READ;
            hvn_pkg::MS_READ:  if (rd_cnt_reg == 2'd3) state_next = hvn_pkg::MS_WRITE;
            hvn_pkg::MS_WRITE:
                if (wr_cnt_reg)
                    state_next = (r_reg != '0) ? hvn_pkg::MS_SUM : hvn_pkg::MS_IDLE;
            hvn_pkg::MS_SUM:   state_next = hvn_pkg::MS_NORM;
            hvn_pkg::MS_NORM:  if (rsp.done) state_next = hvn_pkg::MS_PUSH;
            hvn_pkg::MS_PUSH:
                if (slot_free)
                    state_next = (!vsel_reg && last_row_reg) ? hvn_pkg::MS_SUM
                                                             : hvn_pkg::MS_IDLE;
            default:           state_next = hvn_pkg::MS_IDLE;
        endcase
    end

    // Outputs of the controller: store accesses and the normaliser request.
    always_comb
    begin
        rd_addr = c_reg + AW'(rd_cnt_reg) - AW'(1);
        mem_we  = 1'b0;
        wr_addr = c_reg;
        wd_one  = h_reg;
        wd_two  = m_reg[1];
        if (state_reg == hvn_pkg::MS_WRITE)
        begin
            if (!wr_cnt_reg)
            begin
                // The left neighbour's column moves down one row.
                mem_we  = left_reg;
                wr_addr = c_reg - AW'(1);
                wd_one  = lsamp_reg;
                wd_two  = m_reg[0];
            end
            else
            begin
                // At the end of a row the last column moves down as well.
                mem_we = !right_reg;
            end
        end

        req.start = (state_reg == hvn_pkg::MS_SUM);
        if (vsel_reg)
            // Vertex on the last row itself: nothing below it.
            req.sum = hvn_pkg::face_sums(m_reg[0], m_reg[1], m_reg[2],
                                         lsamp_reg, h_reg, '0, '0, '0,
                                         1'b1, 1'b0, left_reg, right_reg);
        else
            // Vertex one row up: the new sample and its left neighbour lie below.
            req.sum = hvn_pkg::face_sums(t_reg[0], t_reg[1], t_reg[2],
                                         m_reg[0], m_reg[1], m_reg[2],
                                         lsamp_reg, h_reg,
                                         (r_reg >= hvn_pkg::ROW_W'(2)), 1'b1,
                                         left_reg, right_reg);
    end

    hvn_norm u_norm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Row stores.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_one_mem[wr_addr] <= wd_one;
            row_two_mem[wr_addr] <= wd_two;
        end
        rd_one_reg <= row_one_mem[rd_addr];
        rd_two_reg <= row_two_mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hvn_pkg::MS_IDLE;
            grid_width_reg  <= hvn_pkg::GW_W'(hvn_pkg::GW_RESET);
            grid_rows_reg   <= hvn_pkg::GR_W'(hvn_pkg::GR_RESET);
            col_count_reg   <= '0;
            row_count_reg   <= '0;
            left_sample_reg <= '0;
            out_valid_reg   <= 1'b0;
            rd_cnt_reg      <= '0;
            wr_cnt_reg      <= 1'b0;
            vsel_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                if (cfg_index == hvn_pkg::CFG_GRID_WIDTH)
                    grid_width_reg <= cfg_data[hvn_pkg::GW_W-1:0];
                else
                    grid_rows_reg <= cfg_data;
            end

            if (accept)
            begin
                left_sample_reg <= samples.height;
                rd_cnt_reg      <= '0;
                wr_cnt_reg      <= 1'b0;
                vsel_reg        <= 1'b0;
                if (right_cur)
                begin
                    col_count_reg <= c_cur + AW'(1);
                    row_count_reg <= r_cur;
                end
                else
                begin
                    col_count_reg <= '0;
                    row_count_reg <= last_row_cur ? '0 : r_cur + hvn_pkg::ROW_W'(1);
                end
            end

            if (state_reg == hvn_pkg::MS_READ)
                rd_cnt_reg <= rd_cnt_reg + 2'd1;
            if (state_reg == hvn_pkg::MS_WRITE)
                wr_cnt_reg <= !wr_cnt_reg;
            if (push)
                vsel_reg <= 1'b1;

            if (push)
                out_valid_reg <= 1'b1;
            else if (normals.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            c_reg        <= c_cur;
            r_reg        <= r_cur;
            left_reg     <= left_cur;
            right_reg    <= right_cur;
            last_row_reg <= last_row_cur;
            h_reg        <= samples.height;
            lsamp_reg    <= left_sample_reg;
        end
        // Read data arrives in the cycle after its address.
        if (state_reg == hvn_pkg::MS_READ && rd_cnt_reg != 2'd0)
        begin
            t_reg[rd_cnt_reg - 2'd1] <= rd_two_reg;
            m_reg[rd_cnt_reg - 2'd1] <= rd_one_reg;
        end
        if (push)
        begin
            nx_reg       <= rsp.nx;
            ny_reg       <= rsp.ny;
            nz_reg       <= rsp.nz;
            col_out_reg  <= hvn_pkg::COL_W'(c_reg);
            row_out_reg  <= vsel_reg ? r_reg : r_reg - hvn_pkg::ROW_W'(1);
            last_out_reg <= vsel_reg || !last_row_reg;
        end
    end

    assign samples.ready       = (state_reg == hvn_pkg::MS_IDLE);
    assign normals.valid       = out_valid_reg;
    assign normals.normal_x    = nx_reg;
    assign normals.normal_y    = ny_reg;
    assign normals.normal_z    = nz_reg;
    assign normals.vertex_col  = col_out_reg;
    assign normals.vertex_row  = row_out_reg;
    assign normals.last_of_run = last_out_reg;

endmodule
